// File: hw/rtl/akv_pkg.sv
// akv_pkg: shared types and codes for the associative key/value table.
// No dependencies; imported by akv_mem, akv_match and assoc_key_value_table.
`timescale 1ns / 1ps

package akv_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 31;
	localparam int CMD_W = 2;
	localparam int OC_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// outcome codes
	localparam logic [OC_W-1:0] OC_FOUND    = 2'd0;
	localparam logic [OC_W-1:0] OC_MISS     = 2'd1;
	localparam logic [OC_W-1:0] OC_INSERTED = 2'd2;
	localparam logic [OC_W-1:0] OC_FULL     = 2'd3;

	// one table slot as stored in memory
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// scan result flags
	typedef struct packed {
		logic hit;
		logic free;
	} match_flags_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

// File: hw/rtl/assoc_key_value_table.sv
// assoc_key_value_table: fully associative key/value table, one slot scanned per cycle.
// Requests are handled one at a time, set by the single memory read port and key
// comparator walking all slots, plus a write-back step that waits while the output
// register holds an unaccepted result; in_stall stays high until the table is idle again.
// Reset: a clearing pass writes every slot invalid, stall held high.
// Depends on akv_pkg, akv_mem, akv_match.
`timescale 1ns / 1ps

module assoc_key_value_table #(
	parameter int CAPACITY = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [akv_pkg::CMD_W-1:0] command,
	input  logic [akv_pkg::KEY_W-1:0] lookup_key,
	input  logic [akv_pkg::VAL_W-1:0] write_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [akv_pkg::VAL_W-1:0] read_value,
	output logic [akv_pkg::OC_W-1:0]  outcome
);
	import akv_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	state_t state_q, state_d;

	// request registers
	logic [CMD_W-1:0] cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// scan counters
	logic [AW-1:0] clr_q;
	logic [AW-1:0] iss_q;
	logic          iss_act_q;
	logic          chk_vld_s1;
	logic [AW-1:0] chk_idx_s1;

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	entry_t        mem_rdata;

	// compare unit results
	match_flags_t     flags;
	logic [AW-1:0]    hit_idx;
	logic [VAL_W-1:0] hit_val;
	logic [AW-1:0]    free_idx;

	// output register
	logic             out_valid_q;
	logic [VAL_W-1:0] read_value_q;
	logic [OC_W-1:0]  outcome_q;

	logic in_xfer;
	logic scan_done;
	logic out_free;
	logic wb_go;
	logic [VAL_W-1:0] rd_d;
	logic [OC_W-1:0]  oc_d;

	assign in_xfer   = in_valid && !in_stall;
	assign scan_done = chk_vld_s1 && (chk_idx_s1 == LAST);
	assign out_free  = !out_valid_q || !out_stall;

	akv_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(iss_q),
		.rdata(mem_rdata)
	);

	akv_match #(
		.AW(AW)
	) u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_xfer),
		.chk_vld (chk_vld_s1),
		.chk_idx (chk_idx_s1),
		.ent     (mem_rdata),
		.key     (key_q),
		.flags   (flags),
		.hit_idx (hit_idx),
		.hit_val (hit_val),
		.free_idx(free_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == LAST) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_done) state_d = ST_WRITE;
			ST_WRITE: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// outcome of the request from the scan flags
	always_comb begin
		rd_d = '0;
		oc_d = OC_MISS;
		unique case (cmd_q)
			CMD_PUT: begin
				if (flags.hit) oc_d = OC_FOUND;
				else if (flags.free) oc_d = OC_INSERTED;
				else oc_d = OC_FULL;
			end
			CMD_GET: begin
				if (flags.hit) begin
					oc_d = OC_FOUND;
					rd_d = hit_val;
				end
			end
			CMD_REMOVE: begin
				if (flags.hit) oc_d = OC_FOUND;
			end
			default: oc_d = OC_MISS;
		endcase
	end

	// state outputs: handshake, memory ports
	always_comb begin
		in_stall        = 1'b1;
		mem_re          = 1'b0;
		mem_we          = 1'b0;
		mem_waddr       = clr_q;
		mem_wdata.valid = 1'b0;
		mem_wdata.key   = key_q;
		mem_wdata.value = val_q;
		wb_go           = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_SCAN: begin
				mem_re = iss_act_q;
			end
			ST_WRITE: begin
				wb_go = out_free;
				if (flags.hit) begin
					mem_waddr       = hit_idx;
					mem_wdata.valid = (cmd_q == CMD_PUT);
					mem_we          = out_free &&
						((cmd_q == CMD_PUT) || (cmd_q == CMD_REMOVE));
				end else begin
					mem_waddr       = free_idx;
					mem_wdata.valid = 1'b1;
					mem_we          = out_free && flags.free && (cmd_q == CMD_PUT);
				end
			end
			default: in_stall = 1'b1;
		endcase
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= command;
			key_q <= lookup_key;
			val_q <= write_value;
		end
	end

	// clearing pass and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			iss_q      <= '0;
			iss_act_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			chk_vld_s1 <= mem_re;
			chk_idx_s1 <= iss_q;
			if (in_xfer) begin
				iss_q     <= '0;
				iss_act_q <= 1'b1;
			end else if (mem_re) begin
				if (iss_q == LAST) iss_act_q <= 1'b0;
				else iss_q <= iss_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			read_value_q <= rd_d;
			outcome_q    <= oc_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign outcome    = outcome_q;

`ifndef SYNTHESIS
	// no table write while slots are being scanned
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !mem_we)
		else $error("table written during scan");

	// a new result only comes out of write-back
	a_result_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_WRITE))
		else $error("result without write-back");

	// a put into a full table leaves memory alone
	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && (cmd_q == CMD_PUT) && !flags.hit && !flags.free) |-> !mem_we)
		else $error("write on full table");

	// clearing pass runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass restarted");

	// a result is never overwritten before its transfer
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !wb_go)
		else $error("pending result overwritten");
`endif

endmodule

// File: hw/rtl/akv_mem.sv
// akv_mem: slot storage, one write port and one registered read port.
// Depends on akv_pkg (entry_t).
`timescale 1ns / 1ps

module akv_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  akv_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output akv_pkg::entry_t rdata
);
	import akv_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/akv_match.sv
// akv_match: shared key compare unit; checks one slot per cycle and keeps
// the first matching slot and the first free slot. Depends on akv_pkg.
`timescale 1ns / 1ps

module akv_match #(
	parameter int AW = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      chk_vld,
	input  logic [AW-1:0]             chk_idx,
	input  akv_pkg::entry_t           ent,
	input  logic [akv_pkg::KEY_W-1:0] key,
	output akv_pkg::match_flags_t     flags,
	output logic [AW-1:0]             hit_idx,
	output logic [akv_pkg::VAL_W-1:0] hit_val,
	output logic [AW-1:0]             free_idx
);
	import akv_pkg::*;

	match_flags_t     flags_q;
	logic [AW-1:0]    hit_idx_q;
	logic [VAL_W-1:0] hit_val_q;
	logic [AW-1:0]    free_idx_q;
	logic             is_hit;
	logic             is_free;

	// the one key comparator
	assign is_hit  = chk_vld && ent.valid && (ent.key == key);
	assign is_free = chk_vld && !ent.valid;

	// flags: cleared at start, first occurrence wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (start) begin
			flags_q <= '0;
		end else begin
			if (is_hit) flags_q.hit <= 1'b1;
			if (is_free) flags_q.free <= 1'b1;
		end
	end

	// captured slot indexes and value
	always_ff @(posedge clk) begin
		if (is_hit && !flags_q.hit) begin
			hit_idx_q <= chk_idx;
			hit_val_q <= ent.value;
		end
		if (is_free && !flags_q.free) begin
			free_idx_q <= chk_idx;
		end
	end

	assign flags    = flags_q;
	assign hit_idx  = hit_idx_q;
	assign hit_val  = hit_val_q;
	assign free_idx = free_idx_q;

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for assoc_key_value_table (put/get/remove map).
// Depends on akv_pkg and assoc_key_value_table; a shadow table predicts every reply.
`timescale 1ns / 1ps

module tb_top;
	import akv_pkg::*;

	localparam int SLOTS = 64;
	localparam int KEY_POOL = 96;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	typedef struct {
		logic [VAL_W-1:0] read_value;
		logic [OC_W-1:0]  outcome;
	} reply_t;

	// shadow copy of the table plus the queue of replies still owed
	class map_reply_board;
		bit               slot_used [SLOTS];
		logic [KEY_W-1:0] slot_key [SLOTS];
		logic [VAL_W-1:0] slot_val [SLOTS];
		reply_t           owed_replies [$];
		int               errors;

		function new();
			foreach (slot_used[i]) slot_used[i] = 1'b0;
			errors = 0;
		endfunction

		// apply one request to the shadow table and return its reply
		function reply_t apply_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
				logic [VAL_W-1:0] val);
			int hit;
			int free_slot;
			reply_t r;
			hit = -1;
			free_slot = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
				if (free_slot < 0 && !slot_used[i]) free_slot = i;
			end
			r.read_value = '0;
			r.outcome = OC_MISS;
			case (cmd)
				CMD_PUT: begin
					if (hit >= 0) begin
						slot_val[hit] = val;
						r.outcome = OC_FOUND;
					end else if (free_slot >= 0) begin
						slot_used[free_slot] = 1'b1;
						slot_key[free_slot] = key;
						slot_val[free_slot] = val;
						r.outcome = OC_INSERTED;
					end else begin
						r.outcome = OC_FULL;
					end
				end
				CMD_GET: begin
					if (hit >= 0) begin
						r.read_value = slot_val[hit];
						r.outcome = OC_FOUND;
					end
				end
				CMD_REMOVE: begin
					if (hit >= 0) begin
						slot_used[hit] = 1'b0;
						r.outcome = OC_FOUND;
					end
				end
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
				logic [VAL_W-1:0] val);
			owed_replies.insert(owed_replies.size(), apply_request(cmd, key, val));
		endfunction

		function void check_reply(logic [VAL_W-1:0] rd, logic [OC_W-1:0] oc);
			reply_t exp_r;
			if (owed_replies.size() == 0) begin
				$error("unexpected reply: read_value %0h outcome %0d", rd, oc);
				errors++;
				return;
			end
			exp_r = owed_replies.pop_front();
			if (rd !== exp_r.read_value) begin
				$error("read_value: expected %0h, actual %0h", exp_r.read_value, rd);
				errors++;
			end
			if (oc !== exp_r.outcome) begin
				$error("outcome: expected %0d, actual %0d", exp_r.outcome, oc);
				errors++;
			end
		endfunction

		function int owed();
			return owed_replies.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [CMD_W-1:0] command;
	logic [KEY_W-1:0] lookup_key;
	logic [VAL_W-1:0] write_value;
	logic             out_valid;
	logic             out_stall;
	logic [VAL_W-1:0] read_value;
	logic [OC_W-1:0]  outcome;

	map_reply_board   board;
	int               send_idle;
	int               recv_idle;
	int               holds_asked;
	logic [KEY_W-1:0] key_pool [KEY_POOL];

	assoc_key_value_table #(.CAPACITY(SLOTS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.lookup_key (lookup_key),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.outcome    (outcome)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#20ms;
		$display("tb_top: done, errors");
		$finish;
	end

	// offer one request, called at a falling edge, returns at a falling edge
	task automatic send_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
			logic [VAL_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		lookup_key <= key;
		write_value <= val;
		do @(posedge clk); while (in_stall);
		board.note_request(cmd, key, val);
		@(negedge clk);
	endtask

	// receiver: random stall, plus a long hold-off on request
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				holds_served = holds_asked;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_reply(read_value, outcome);
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		int r;
		int put_pct;
		int rem_pct;

		board = new();
		send_idle = 30;
		recv_idle = 46;
		holds_asked = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_PUT;
		lookup_key = '0;
		write_value = '0;
		foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, extremes, update, remove, unused command
		send_request(CMD_GET, '0, '0);
		send_request(CMD_PUT, '0, '0);
		send_request(CMD_PUT, KEY_MAX, VAL_MAX);
		send_request(CMD_GET, '0, VAL_MAX);
		send_request(CMD_GET, KEY_MAX, '0);
		send_request(CMD_PUT, '0, VAL_MAX);
		send_request(CMD_GET, '0, '0);
		send_request(CMD_REMOVE, KEY_MAX, '0);
		send_request(CMD_REMOVE, KEY_MAX, '0);
		send_request(CMD_GET, KEY_MAX, '0);
		send_request(CMD_UNUSED, '0, 31'h1234);
		send_request(CMD_UNUSED, KEY_MAX, VAL_MAX);
		send_request(CMD_GET, '0, '0);
		send_request(CMD_PUT, 31'h5555_5555, 31'h2AAA_AAAA);
		send_request(CMD_PUT, 31'h2AAA_AAAA, 31'h5555_5555);
		send_request(CMD_GET, 31'h5555_5555, '0);
		send_request(CMD_GET, 31'h2AAA_AAAA, '0);
		send_request(CMD_REMOVE, '0, '0);
		send_request(CMD_PUT, 31'h0000_0001, 31'h4000_0000);
		send_request(CMD_GET, 31'h0000_0001, '0);
		send_request(CMD_REMOVE, 31'h0000_0002, VAL_MAX);

		// random: alternate fill-heavy and drain-heavy stretches over a key pool
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle = 30; recv_idle = 46; end
				1: begin send_idle = 46; recv_idle = 30; end
				default: begin
					send_idle = 0;
					recv_idle = 0;
					holds_asked++;
				end
			endcase
			for (int n = 0; n < 530; n++) begin
				if (((n / 130) % 2) == 0) begin
					put_pct = 60;
					rem_pct = 14;
				end else begin
					put_pct = 25;
					rem_pct = 41;
				end
				r = $urandom_range(0, 99);
				if (r < put_pct) cmd = CMD_PUT;
				else if (r < put_pct + rem_pct) cmd = CMD_REMOVE;
				else if (r < 96) cmd = CMD_GET;
				else cmd = CMD_UNUSED;
				if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
				else key = key_pool[$urandom_range(0, KEY_POOL - 1)];
				case ($urandom_range(0, 15))
					0: val = '0;
					1: val = VAL_MAX;
					default: val = VAL_W'($urandom);
				endcase
				send_request(cmd, key, val);
			end
		end
		in_valid <= 1'b0;

		// drain, then allow one more full scan for stray replies
		while (board.owed() > 0) @(posedge clk);
		repeat (2 * SLOTS + 10) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
